[rtl/bwu_pkg.sv]
// ----------------------------------------------------------------------------
// bwu_pkg
// Shared widths, types and constants of the barycentric weights unit.
// ----------------------------------------------------------------------------
package bwu_pkg;

  localparam int COORD_W    = 16;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int COMP_W     = PROD_W + 1;
  localparam int MAG_W      = PROD_W;
  localparam int SQ_W       = 68;
  localparam int ROOT_W     = SQ_W / 2;
  localparam int WEIGHT_W   = 18;
  localparam int MIN_AREA_W = 16;
  localparam int NUM_CROSS  = 3;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam int WEIGHT_FRAC_BITS_DEF = 14;
  localparam int WEIGHT_MAX_I = 131071;
  localparam int WEIGHT_MIN_I = -131072;

  // cross product lanes
  localparam int X_ABC = 0;
  localparam int X_PBC = 1;
  localparam int X_PCA = 2;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec_t;

  typedef logic [NUM_CROSS-1:0][SQ_W-1:0]   sq3_t;
  typedef logic [NUM_CROSS-1:0][ROOT_W-1:0] root3_t;

  // register index, taken from the word address
  typedef enum logic {
    REG_MIN_AREA = 1'b0
  } reg_idx_t;

endpackage

[rtl/barycentric_weights_unit.sv]
// ----------------------------------------------------------------------------
// barycentric_weights_unit
// Barycentric weights of a query point against a 3D triangle by area ratios.
// ----------------------------------------------------------------------------
// Usage:
//   Item channel (item_valid/item_ready) carries vertices A, B, C and point P
//   in signed Q11.4. Result channel (result_valid/result_ready) carries
//   weight_a/b/c in signed Q3.14 (WEIGHT_FRAC_BITS fraction bits), saturated
//   to 18 bits, and the degenerate flag.
//   The pipeline has five cross product stages, one stage per root bit in
//   the square root, and one stage per quotient bit in the dividers.
//   Throughput is one transfer per clock while the pipeline advances; every
//   stage is a pipeline register. When the receiver holds result_ready low
//   with a result waiting, the whole pipeline freezes and item_ready drops;
//   nothing is lost or repeated. Reset clears all valid bits and sets
//   min_area to 1. min_area is written over the APB port at byte address 0;
//   the user writes it only while idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module barycentric_weights_unit #(
  parameter int WEIGHT_FRAC_BITS = bwu_pkg::WEIGHT_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bwu_pkg::ADDR_W-1:0]     paddr,
  input  logic [bwu_pkg::DATA_W-1:0]     pwdata,
  output logic [bwu_pkg::DATA_W-1:0]     prdata,
  output logic                           pready,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  bwu_pkg::coord_t                a_x,
  input  bwu_pkg::coord_t                a_y,
  input  bwu_pkg::coord_t                a_z,
  input  bwu_pkg::coord_t                b_x,
  input  bwu_pkg::coord_t                b_y,
  input  bwu_pkg::coord_t                b_z,
  input  bwu_pkg::coord_t                c_x,
  input  bwu_pkg::coord_t                c_y,
  input  bwu_pkg::coord_t                c_z,
  input  bwu_pkg::coord_t                p_x,
  input  bwu_pkg::coord_t                p_y,
  input  bwu_pkg::coord_t                p_z,
  output logic                           result_valid,
  input  logic                           result_ready,
  output logic signed [bwu_pkg::WEIGHT_W-1:0] weight_a,
  output logic signed [bwu_pkg::WEIGHT_W-1:0] weight_b,
  output logic signed [bwu_pkg::WEIGHT_W-1:0] weight_c,
  output logic                           degenerate
);
  import bwu_pkg::*;

  localparam int QW = WEIGHT_FRAC_BITS + 20;
  localparam int GW = QW + 2;
  localparam int DW = ROOT_W + 1;

  localparam logic signed [GW-1:0] G_MAX = GW'(WEIGHT_MAX_I);
  localparam logic signed [GW-1:0] G_MIN = GW'(WEIGHT_MIN_I);
  localparam logic signed [GW-1:0] G_ONE = GW'(2 ** WEIGHT_FRAC_BITS);
  localparam logic signed [WEIGHT_W-1:0] DEG_WEIGHT =
    (WEIGHT_FRAC_BITS > WEIGHT_W - 1) ? WEIGHT_W'(WEIGHT_MIN_I)
                                      : WEIGHT_W'(-(2 ** WEIGHT_FRAC_BITS));

  logic [MIN_AREA_W-1:0] min_area;
  reg_idx_t              reg_idx;
  logic                  en;

  logic                  x_vld;
  sq3_t                  x_sq;
  logic                  r_vld;
  root3_t                r_root;
  logic                  d_vld;
  logic [DW-1:0]         d_dd;
  logic [1:0][QW-1:0]    d_q;

  logic signed [GW-1:0]       gamma;
  logic signed [WEIGHT_W-1:0] wa_next, wb_next, wc_next;
  logic                       deg_next;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1]);

  always_comb begin
    unique case (reg_idx)
      REG_MIN_AREA: prdata = DATA_W'(min_area);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_area <= MIN_AREA_W'(1);
    end else if (psel && penable && pwrite && pready && reg_idx == REG_MIN_AREA) begin
      min_area <= pwdata[MIN_AREA_W-1:0];
    end
  end

  // global advance: the output register is empty or being drained
  assign en         = !result_valid || result_ready;
  assign item_ready = en;

  bwu_cross u_cross (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .vld_in  (item_valid),
    .a       ('{a_x, a_y, a_z}),
    .b       ('{b_x, b_y, b_z}),
    .c       ('{c_x, c_y, c_z}),
    .p       ('{p_x, p_y, p_z}),
    .vld_out (x_vld),
    .s_out   (x_sq)
  );

  bwu_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vld_in   (x_vld),
    .s_in     (x_sq),
    .vld_out  (r_vld),
    .root_out (r_root)
  );

  bwu_div #(
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS),
    .QW               (QW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .vld_in  (r_vld),
    .den_in  (r_root[X_ABC]),
    .num_in  ({r_root[X_PCA], r_root[X_PBC]}),
    .vld_out (d_vld),
    .dd_out  (d_dd),
    .q_out   (d_q)
  );

  // gamma, saturation and degenerate check
  always_comb begin
    gamma    = G_ONE - $signed(GW'(d_q[0])) - $signed(GW'(d_q[1]));
    deg_next = (d_dd == '0) || (d_dd < DW'({min_area, 2'b00}));
    wc_next  = (d_q[0] > QW'(WEIGHT_MAX_I)) ? WEIGHT_W'(WEIGHT_MAX_I)
                                             : $signed(d_q[0][WEIGHT_W-1:0]);
    wb_next  = (d_q[1] > QW'(WEIGHT_MAX_I)) ? WEIGHT_W'(WEIGHT_MAX_I)
                                             : $signed(d_q[1][WEIGHT_W-1:0]);
    priority if (gamma > G_MAX) begin
      wa_next = WEIGHT_W'(WEIGHT_MAX_I);
    end else if (gamma < G_MIN) begin
      wa_next = WEIGHT_W'(WEIGHT_MIN_I);
    end else begin
      wa_next = gamma[WEIGHT_W-1:0];
    end
    if (deg_next) begin
      wa_next = DEG_WEIGHT;
      wb_next = DEG_WEIGHT;
      wc_next = DEG_WEIGHT;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      weight_a   <= wa_next;
      weight_b   <= wb_next;
      weight_c   <= wc_next;
      degenerate <= deg_next;
    end
  end

`ifndef SYNTH
  // a degenerate transfer carries the fixed weight on all three lanes
  a_deg_weights: assert property (@(posedge clk) disable iff (rst)
    result_valid && degenerate |->
      weight_a == DEG_WEIGHT && weight_b == DEG_WEIGHT && weight_c == DEG_WEIGHT)
    else $error("degenerate result with unexpected weights");

  // area ratios never go negative
  a_ratio_sign: assert property (@(posedge clk) disable iff (rst)
    result_valid && !degenerate |-> !weight_b[WEIGHT_W-1] && !weight_c[WEIGHT_W-1])
    else $error("negative area ratio");

  // pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");
`endif

endmodule

[rtl/bwu_cross.sv]
// ----------------------------------------------------------------------------
// bwu_cross
// Edge differences, cross products and squared lengths in five stages.
// ----------------------------------------------------------------------------
module bwu_cross (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vld_in,
  input  bwu_pkg::vec_t a,
  input  bwu_pkg::vec_t b,
  input  bwu_pkg::vec_t c,
  input  bwu_pkg::vec_t p,
  output logic          vld_out,
  output bwu_pkg::sq3_t s_out
);
  import bwu_pkg::*;

  localparam int NSTG = 5;

  coord_t av[3], bv[3], cv[3], pv[3];
  logic signed [DIFF_W-1:0] u_n [NUM_CROSS][3];
  logic signed [DIFF_W-1:0] v_n [NUM_CROSS][3];
  logic signed [DIFF_W-1:0] u_q [NUM_CROSS][3];
  logic signed [DIFF_W-1:0] v_q [NUM_CROSS][3];
  logic signed [PROD_W-1:0] prod_q [NUM_CROSS][6];
  logic signed [COMP_W-1:0] comp_q [NUM_CROSS][3];
  logic [SQ_W-1:0]          sq_q [NUM_CROSS][3];
  logic [SQ_W-1:0]          sum_q [NUM_CROSS];
  logic [NSTG-1:0]          vld;

  assign av = '{a.x, a.y, a.z};
  assign bv = '{b.x, b.y, b.z};
  assign cv = '{c.x, c.y, c.z};
  assign pv = '{p.x, p.y, p.z};

  // edge vectors for the three cross products
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u_n[X_ABC][i] = DIFF_W'(bv[i]) - DIFF_W'(av[i]);
      v_n[X_ABC][i] = DIFF_W'(cv[i]) - DIFF_W'(av[i]);
      u_n[X_PBC][i] = DIFF_W'(pv[i]) - DIFF_W'(bv[i]);
      v_n[X_PBC][i] = DIFF_W'(pv[i]) - DIFF_W'(cv[i]);
      u_n[X_PCA][i] = DIFF_W'(pv[i]) - DIFF_W'(cv[i]);
      v_n[X_PCA][i] = DIFF_W'(pv[i]) - DIFF_W'(av[i]);
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTG-2:0], vld_in};
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_CROSS; k++) begin
        for (int i = 0; i < 3; i++) begin
          u_q[k][i] <= u_n[k][i];
          v_q[k][i] <= v_n[k][i];
        end
        prod_q[k][0] <= u_q[k][1] * v_q[k][2];
        prod_q[k][1] <= u_q[k][2] * v_q[k][1];
        prod_q[k][2] <= u_q[k][2] * v_q[k][0];
        prod_q[k][3] <= u_q[k][0] * v_q[k][2];
        prod_q[k][4] <= u_q[k][0] * v_q[k][1];
        prod_q[k][5] <= u_q[k][1] * v_q[k][0];
        for (int i = 0; i < 3; i++) begin
          comp_q[k][i] <= COMP_W'(prod_q[k][2*i]) - COMP_W'(prod_q[k][2*i+1]);
        end
        for (int i = 0; i < 3; i++) begin
          sq_q[k][i] <= SQ_W'(MAG_W'(comp_q[k][i] < 0 ? -comp_q[k][i] : comp_q[k][i]))
                        * SQ_W'(MAG_W'(comp_q[k][i] < 0 ? -comp_q[k][i] : comp_q[k][i]));
        end
        sum_q[k] <= sq_q[k][0] + sq_q[k][1] + sq_q[k][2];
      end
    end
  end

  assign vld_out = vld[NSTG-1];

  always_comb begin
    for (int k = 0; k < NUM_CROSS; k++) begin
      s_out[k] = sum_q[k];
    end
  end

endmodule

[rtl/bwu_sqrt.sv]
// ----------------------------------------------------------------------------
// bwu_sqrt
// Pipelined digit-by-digit integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module bwu_sqrt (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            vld_in,
  input  bwu_pkg::sq3_t   s_in,
  output logic            vld_out,
  output bwu_pkg::root3_t root_out
);
  import bwu_pkg::*;

  localparam int REM_W = ROOT_W + 3;

  logic [REM_W-1:0]  rem_q  [ROOT_W][NUM_CROSS];
  logic [ROOT_W-1:0] root_q [ROOT_W][NUM_CROSS];
  logic [SQ_W-1:0]   rad_q  [ROOT_W][NUM_CROSS];
  logic              vld_q  [ROOT_W];

  for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
    logic [REM_W-1:0]  rem_i  [NUM_CROSS];
    logic [ROOT_W-1:0] root_i [NUM_CROSS];
    logic [SQ_W-1:0]   rad_i  [NUM_CROSS];
    logic              vld_i;
    logic [REM_W-1:0]  rem_sh [NUM_CROSS];
    logic [REM_W-1:0]  trial  [NUM_CROSS];

    // stage input select
    if (g == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < NUM_CROSS; l++) begin
          rem_i[l]  = '0;
          root_i[l] = '0;
          rad_i[l]  = s_in[l];
        end
        vld_i = vld_in;
      end
    end else begin : g_next
      always_comb begin
        for (int l = 0; l < NUM_CROSS; l++) begin
          rem_i[l]  = rem_q[g-1][l];
          root_i[l] = root_q[g-1][l];
          rad_i[l]  = rad_q[g-1][l];
        end
        vld_i = vld_q[g-1];
      end
    end

    // bring down two radicand bits and try the next root bit
    always_comb begin
      for (int l = 0; l < NUM_CROSS; l++) begin
        rem_sh[l] = {rem_i[l][REM_W-3:0], rad_i[l][SQ_W-1 -: 2]};
        trial[l]  = REM_W'({root_i[l], 2'b01});
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[g] <= 1'b0;
      end else if (en) begin
        vld_q[g] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < NUM_CROSS; l++) begin
          rad_q[g][l] <= rad_i[l] << 2;
          if (rem_sh[l] >= trial[l]) begin
            rem_q[g][l]  <= rem_sh[l] - trial[l];
            root_q[g][l] <= {root_i[l][ROOT_W-2:0], 1'b1};
          end else begin
            rem_q[g][l]  <= rem_sh[l];
            root_q[g][l] <= {root_i[l][ROOT_W-2:0], 1'b0};
          end
        end
      end
    end
  end

  assign vld_out = vld_q[ROOT_W-1];

  always_comb begin
    for (int l = 0; l < NUM_CROSS; l++) begin
      root_out[l] = root_q[ROOT_W-1][l];
    end
  end

endmodule

[rtl/bwu_div.sv]
// ----------------------------------------------------------------------------
// bwu_div
// Two-lane pipelined restoring divider for the rounded area ratios,
// one quotient bit per stage, quotient capped at all ones on overflow.
// ----------------------------------------------------------------------------
module bwu_div #(
  parameter int WEIGHT_FRAC_BITS = bwu_pkg::WEIGHT_FRAC_BITS_DEF,
  parameter int QW               = WEIGHT_FRAC_BITS + 20
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          vld_in,
  input  logic [bwu_pkg::ROOT_W-1:0]    den_in,
  input  logic [1:0][bwu_pkg::ROOT_W-1:0] num_in,
  output logic                          vld_out,
  output logic [bwu_pkg::ROOT_W:0]      dd_out,
  output logic [1:0][QW-1:0]            q_out
);
  import bwu_pkg::*;

  localparam int NW = ROOT_W + WEIGHT_FRAC_BITS + 2;
  localparam int DW = ROOT_W + 1;
  localparam int CW = DW + QW;

  logic [NW-1:0] n_n [2];
  logic          ovf_n [2];
  logic [NW-1:0] p_n [2];
  logic          p_ovf [2];
  logic [DW-1:0] p_d;
  logic          p_vld;

  logic [DW-1:0] rem_q [QW][2];
  logic [NW-1:0] n_q   [QW][2];
  logic [QW-1:0] q_q   [QW][2];
  logic          ovf_q [QW][2];
  logic [DW-1:0] d_q   [QW];
  logic          vld_q [QW];

  // numerator with rounding term and overflow check
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      n_n[l]   = (NW'(num_in[l]) << (WEIGHT_FRAC_BITS + 1)) + NW'(den_in);
      ovf_n[l] = CW'(n_n[l]) >= (CW'({den_in, 1'b0}) << QW);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else if (en) begin
      p_vld <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_d <= {den_in, 1'b0};
      for (int l = 0; l < 2; l++) begin
        p_n[l]   <= n_n[l];
        p_ovf[l] <= ovf_n[l];
      end
    end
  end

  for (genvar g = 0; g < QW; g++) begin : g_step
    logic [DW-1:0] rem_i [2];
    logic [NW-1:0] n_i   [2];
    logic [QW-1:0] q_i   [2];
    logic          ovf_i [2];
    logic [DW-1:0] d_i;
    logic          vld_i;
    logic [DW:0]   rem2  [2];

    // stage input select
    if (g == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < 2; l++) begin
          rem_i[l] = DW'(p_n[l][NW-1:QW]);
          n_i[l]   = p_n[l];
          q_i[l]   = '0;
          ovf_i[l] = p_ovf[l];
        end
        d_i   = p_d;
        vld_i = p_vld;
      end
    end else begin : g_next
      always_comb begin
        for (int l = 0; l < 2; l++) begin
          rem_i[l] = rem_q[g-1][l];
          n_i[l]   = n_q[g-1][l];
          q_i[l]   = q_q[g-1][l];
          ovf_i[l] = ovf_q[g-1][l];
        end
        d_i   = d_q[g-1];
        vld_i = vld_q[g-1];
      end
    end

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        rem2[l] = {rem_i[l], n_i[l][QW-1-g]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[g] <= 1'b0;
      end else if (en) begin
        vld_q[g] <= vld_i;
      end
    end

    // compare and subtract
    always_ff @(posedge clk) begin
      if (en) begin
        d_q[g] <= d_i;
        for (int l = 0; l < 2; l++) begin
          n_q[g][l]   <= n_i[l];
          ovf_q[g][l] <= ovf_i[l];
          if (rem2[l] >= {1'b0, d_i}) begin
            rem_q[g][l] <= DW'(rem2[l] - {1'b0, d_i});
            q_q[g][l]   <= q_i[l] | (QW'(1) << (QW - 1 - g));
          end else begin
            rem_q[g][l] <= DW'(rem2[l]);
            q_q[g][l]   <= q_i[l];
          end
        end
      end
    end
  end

  assign vld_out = vld_q[QW-1];
  assign dd_out  = d_q[QW-1];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      q_out[l] = ovf_q[QW-1][l] ? '1 : q_q[QW-1][l];
    end
  end

endmodule

[tb/tb_barycentric_weights_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_barycentric_weights_unit
// Drives triangle/point items with random idling on both channels, predicts
// the barycentric weights with an exact integer model and compares every
// result transfer in order. min_area is rewritten over APB between phases.
// ----------------------------------------------------------------------------
module tb_barycentric_weights_unit;
  import bwu_pkg::*;

  localparam int WFB = WEIGHT_FRAC_BITS_DEF;
  localparam int LATENCY = 5 + 34 + 1 + WFB + 20 + 1;

  typedef struct {
    logic [15:0] c [12];
  } tri_item_t;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] wa;
    logic signed [WEIGHT_W-1:0] wb;
    logic signed [WEIGHT_W-1:0] wc;
    logic                       degen;
  } weights_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic item_valid = 1'b0;
  logic item_ready;
  coord_t a_x = '0, a_y = '0, a_z = '0, b_x = '0, b_y = '0, b_z = '0;
  coord_t c_x = '0, c_y = '0, c_z = '0, p_x = '0, p_y = '0, p_z = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  logic signed [WEIGHT_W-1:0] weight_a, weight_b, weight_c;
  logic degenerate;

  barycentric_weights_unit u_top (.*);

  always #5 clk = ~clk;

  initial begin
    #50ms;
    $display("*** FAILED ***");
    $finish;
  end

  logic [15:0] min_area_model = 16'd1;
  weights_t    pending_weights [$];
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_off_cycles = 0;

  // exact floor(sqrt(|u x v|^2))
  function automatic logic [ROOT_W-1:0] cross_root(longint u [3], longint v [3]);
    longint cx, cy, cz;
    logic [SQ_W-1:0] s, t;
    logic [ROOT_W-1:0] r, cand;
    cx = u[1] * v[2] - u[2] * v[1];
    cy = u[2] * v[0] - u[0] * v[2];
    cz = u[0] * v[1] - u[1] * v[0];
    s = 68'(128'(cx) * 128'(cx)) + 68'(128'(cy) * 128'(cy)) + 68'(128'(cz) * 128'(cz));
    r = '0;
    for (int bitn = ROOT_W - 1; bitn >= 0; bitn--) begin
      cand = r | (ROOT_W'(1) << bitn);
      t = SQ_W'(cand) * SQ_W'(cand);
      if (t <= s) r = cand;
    end
    return r;
  endfunction

  function automatic logic signed [WEIGHT_W-1:0] sat_weight(longint v);
    if (v > WEIGHT_MAX_I) return WEIGHT_W'(WEIGHT_MAX_I);
    if (v < WEIGHT_MIN_I) return WEIGHT_W'(WEIGHT_MIN_I);
    return WEIGHT_W'(v);
  endfunction

  function automatic weights_t predict_weights(tri_item_t it);
    longint a [3], b [3], c [3], p [3];
    longint ab [3], ac [3], ap [3], bp [3], cp [3];
    longint r_abc, r_pbc, r_pca, alpha, beta;
    weights_t w;
    for (int i = 0; i < 3; i++) begin
      a[i] = longint'($signed(it.c[i]));
      b[i] = longint'($signed(it.c[3 + i]));
      c[i] = longint'($signed(it.c[6 + i]));
      p[i] = longint'($signed(it.c[9 + i]));
    end
    for (int i = 0; i < 3; i++) begin
      ab[i] = b[i] - a[i];
      ac[i] = c[i] - a[i];
      ap[i] = p[i] - a[i];
      bp[i] = p[i] - b[i];
      cp[i] = p[i] - c[i];
    end
    r_abc = longint'(cross_root(ab, ac));
    if (r_abc == 0 || r_abc < 2 * longint'(min_area_model)) begin
      w.wa = sat_weight(-(longint'(1) << WFB));
      w.wb = w.wa;
      w.wc = w.wa;
      w.degen = 1'b1;
      return w;
    end
    r_pbc = longint'(cross_root(bp, cp));
    r_pca = longint'(cross_root(cp, ap));
    alpha = ((r_pbc << (WFB + 1)) + r_abc) / (2 * r_abc);
    beta  = ((r_pca << (WFB + 1)) + r_abc) / (2 * r_abc);
    w.wa = sat_weight((longint'(1) << WFB) - alpha - beta);
    w.wb = sat_weight(beta);
    w.wc = sat_weight(alpha);
    w.degen = 1'b0;
    return w;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic apb_write_min_area(logic [15:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'(4 * REG_MIN_AREA); pwdata <= {16'h0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    min_area_model = val;
  endtask

  // stop offering, wait for drain, then let the pipeline run empty
  task automatic drain_pipeline();
    item_valid <= 1'b0;
    while (pending_weights.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  // one item transfer on the input channel
  task automatic send_item(tri_item_t it, bit has_expect, weights_t want);
    weights_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    {a_x, a_y, a_z, b_x, b_y, b_z} <= {it.c[0], it.c[1], it.c[2], it.c[3], it.c[4], it.c[5]};
    {c_x, c_y, c_z, p_x, p_y, p_z} <= {it.c[6], it.c[7], it.c[8], it.c[9], it.c[10], it.c[11]};
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    pred = predict_weights(it);
    if (has_expect && pred != want)
      report_mismatch("directed table entry", pred.wa, want.wa);
    pending_weights.insert(pending_weights.size(), pred);
  endtask

  // result side
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (pending_weights.size() == 0) begin
        report_mismatch("unexpected result", weight_a, 0);
      end else begin
        weights_t w;
        w = pending_weights.pop_front();
        if (weight_a !== w.wa) report_mismatch("weight_a", weight_a, w.wa);
        if (weight_b !== w.wb) report_mismatch("weight_b", weight_b, w.wb);
        if (weight_c !== w.wc) report_mismatch("weight_c", weight_c, w.wc);
        if (degenerate !== w.degen) report_mismatch("degenerate", degenerate, w.degen);
      end
    end
  end

  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic tri_item_t make_item(int kind);
    tri_item_t it;
    logic [15:0] sc;
    for (int i = 0; i < 12; i++) it.c[i] = 16'($urandom);
    case (kind)
      0: ;
      1: begin
        // small triangle with point nearby
        for (int i = 0; i < 12; i++) it.c[i] = 16'($signed($urandom_range(400)) - 200);
      end
      2: begin
        // point on a combination of vertices
        for (int i = 0; i < 3; i++) begin
          it.c[i] = 16'($signed($urandom_range(4000)) - 2000);
          it.c[3 + i] = 16'($signed($urandom_range(4000)) - 2000);
          it.c[6 + i] = 16'($signed($urandom_range(4000)) - 2000);
          it.c[9 + i] = 16'(($signed(it.c[i]) + $signed(it.c[3 + i]) + $signed(it.c[6 + i])) / 3);
        end
      end
      3: begin
        // collinear vertices
        sc = 16'($urandom_range(3));
        for (int i = 0; i < 3; i++) begin
          it.c[i] = 16'($signed($urandom_range(2000)) - 1000);
          it.c[3 + i] = it.c[i] + 16'($signed($urandom_range(200)) - 100);
          it.c[6 + i] = it.c[i] + sc * (it.c[3 + i] - it.c[i]);
        end
      end
      default: begin
        // tiny triangle near the area threshold
        for (int i = 0; i < 12; i++) it.c[i] = 16'($signed($urandom_range(8)) - 4);
      end
    endcase
    return it;
  endfunction

  tri_item_t dir_items [16];
  weights_t  dir_want  [16];
  bit        dir_known [16];

  initial begin
    weights_t dgn, none;
    dgn.wa = sat_weight(-(longint'(1) << WFB)); dgn.wb = dgn.wa; dgn.wc = dgn.wa;
    dgn.degen = 1'b1;
    none = dgn;
    // directed table
    for (int r = 0; r < 16; r++) begin
      for (int i = 0; i < 12; i++) dir_items[r].c[i] = 16'h0;
      dir_known[r] = 1'b0;
      dir_want[r] = none;
    end
    // all zero: degenerate
    dir_known[0] = 1'b1; dir_want[0] = dgn;
    // all max: degenerate
    for (int i = 0; i < 12; i++) dir_items[1].c[i] = 16'h7fff;
    dir_known[1] = 1'b1; dir_want[1] = dgn;
    // all min: degenerate
    for (int i = 0; i < 12; i++) dir_items[2].c[i] = 16'h8000;
    dir_known[2] = 1'b1; dir_want[2] = dgn;
    // unit right triangle, P at A: sub-triangle PBC is the whole, weight_c one
    dir_items[3].c[3] = 16'd16; dir_items[3].c[7] = 16'd16;
    dir_known[3] = 1'b1;
    dir_want[3].wa = '0; dir_want[3].wb = '0; dir_want[3].wc = WEIGHT_W'(1 << WFB);
    dir_want[3].degen = 1'b0;
    // P at B and C
    dir_items[4] = dir_items[3]; dir_items[4].c[9] = 16'd16;
    dir_items[5] = dir_items[3]; dir_items[5].c[10] = 16'd16;
    // extreme triangle spanning the box, far points
    dir_items[6].c[0] = 16'h8000; dir_items[6].c[1] = 16'h8000; dir_items[6].c[2] = 16'h8000;
    dir_items[6].c[3] = 16'h7fff; dir_items[6].c[4] = 16'h8000; dir_items[6].c[5] = 16'h7fff;
    dir_items[6].c[6] = 16'h8000; dir_items[6].c[7] = 16'h7fff; dir_items[6].c[8] = 16'h7fff;
    dir_items[6].c[9] = 16'h7fff; dir_items[6].c[10] = 16'h7fff; dir_items[6].c[11] = 16'h8000;
    // tiny triangle with far point: degenerate at the reset min_area
    dir_items[7] = dir_items[3];
    dir_items[7].c[3] = 16'd1; dir_items[7].c[7] = 16'd1;
    dir_items[7].c[9] = 16'h7fff; dir_items[7].c[10] = 16'h7fff; dir_items[7].c[11] = 16'h8000;
    dir_items[8] = dir_items[7]; dir_items[8].c[9] = 16'h8000; dir_items[8].c[10] = 16'h8000;
    // collinear
    dir_items[9].c[3] = 16'd5; dir_items[9].c[6] = 16'd10;
    dir_known[9] = 1'b1; dir_want[9] = dgn;
    for (int r = 10; r < 16; r++) dir_items[r] = make_item(r % 5);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part at reset min_area
    send_idle_pct = 33; recv_idle_pct = 52;
    for (int r = 0; r < 16; r++) send_item(dir_items[r], dir_known[r], dir_want[r]);
    drain_pipeline();

    // phases with different min_area and idling
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: apb_write_min_area(16'd0);
        1: apb_write_min_area(16'hffff);
        2: apb_write_min_area(16'd1);
        3: apb_write_min_area(16'd3);
        4: apb_write_min_area(16'($urandom_range(65535)));
        default: apb_write_min_area(16'd2);
      endcase
      if (ph < 2) begin
        send_idle_pct = 33; recv_idle_pct = 52;
      end else if (ph < 4) begin
        send_idle_pct = 52; recv_idle_pct = 33;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      for (int n = 0; n < 175; n++) begin
        if (n == 20 && ph == 4) hold_off_cycles = 3 * LATENCY;
        if (n == 90) begin
          // sender waits for all results
          item_valid <= 1'b0;
          do @(posedge clk); while (pending_weights.size() != 0);
        end
        send_item(make_item($urandom_range(9) < 4 ? 0 : $urandom_range(1, 4)), 1'b0, none);
      end
      drain_pipeline();
    end

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[barycentric_weights_unit.f]
rtl/bwu_pkg.sv
rtl/bwu_cross.sv
rtl/bwu_sqrt.sv
rtl/bwu_div.sv
rtl/barycentric_weights_unit.sv
tb/tb_barycentric_weights_unit.sv
